// ===== rtl/dssh_pkg.sv =====
// Shared types and constants for the serial setup handshake block.
// No dependencies; used by every module of the block.
package dssh_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHAN_W       = 6;
    localparam int SEEN_W       = 4;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 64;

    localparam logic [7:0] REPLY_ACK         = 8'h00;
    localparam logic [7:0] REPLY_SYNC_FAIL   = 8'hFF;
    localparam logic [7:0] REPLY_BAD_CHANNEL = 8'hFE;

    localparam logic [7:0]        RST_CONFIRM_BYTE = 8'd1;
    localparam logic [7:0]        RST_RESTART_BYTE = 8'd42;
    localparam logic [SEEN_W-1:0] RST_REPEATS      = SEEN_W'(4);
    localparam logic [63:0]       RST_MASK         = 64'd0;

    // register index = paddr[4:3]
    typedef enum logic [1:0] {
        REG_CONFIRM = 2'd0,
        REG_RESTART = 2'd1,
        REG_REPEATS = 2'd2,
        REG_MASK    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]        confirm_byte;
        logic [7:0]        restart_byte;
        logic [SEEN_W-1:0] restart_repeats;
        logic [63:0]       valid_channel_mask;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] reply_byte;
        logic       restart_request;
        logic       setup_done;
    } t_result;

endpackage

// ===== rtl/dssh_regs.sv =====
// APB configuration registers of the serial setup handshake block.
// Depends on dssh_pkg.
module dssh_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dssh_pkg::ADDR_W-1:0] paddr,
    input  logic [dssh_pkg::DATA_W-1:0] pwdata,
    output logic [dssh_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dssh_pkg::t_cfg             o_cfg
);

    dssh_pkg::t_cfg     r_cfg;
    dssh_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = dssh_pkg::t_reg_idx'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_byte       <= dssh_pkg::RST_CONFIRM_BYTE;
            r_cfg.restart_byte       <= dssh_pkg::RST_RESTART_BYTE;
            r_cfg.restart_repeats    <= dssh_pkg::RST_REPEATS;
            r_cfg.valid_channel_mask <= dssh_pkg::RST_MASK;
        end else if (wr_en) begin
            unique case (reg_idx)
                dssh_pkg::REG_CONFIRM: begin
                    r_cfg.confirm_byte <= pwdata[7:0];
                end
                dssh_pkg::REG_RESTART: begin
                    r_cfg.restart_byte <= pwdata[7:0];
                end
                dssh_pkg::REG_REPEATS: begin
                    r_cfg.restart_repeats <= pwdata[dssh_pkg::SEEN_W-1:0];
                end
                dssh_pkg::REG_MASK: begin
                    r_cfg.valid_channel_mask <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            dssh_pkg::REG_CONFIRM: prdata = dssh_pkg::DATA_W'(r_cfg.confirm_byte);
            dssh_pkg::REG_RESTART: prdata = dssh_pkg::DATA_W'(r_cfg.restart_byte);
            dssh_pkg::REG_REPEATS: prdata = dssh_pkg::DATA_W'(r_cfg.restart_repeats);
            dssh_pkg::REG_MASK:    prdata = r_cfg.valid_channel_mask;
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/dssh_ctrl.sv =====
// Handshake controller: phase machine, channel table and reply decode.
// Depends on dssh_pkg. Reply is combinational from the accepted byte.
module dssh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  dssh_pkg::t_cfg      i_cfg,
    output dssh_pkg::t_result   o_res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_FILL  = 2'd2,
        PH_RUN   = 2'd3
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [dssh_pkg::CNT_W-1:0]       r_count, n_count;
    logic [dssh_pkg::CNT_W-1:0]       r_fill_index, n_fill_index;
    logic [dssh_pkg::SEEN_W-1:0]      r_seen, n_seen;
    logic [dssh_pkg::CHAN_W-1:0]      r_table [dssh_pkg::MAX_CHANNELS];

    logic                             chan_ok;
    logic                             tbl_we;
    logic [dssh_pkg::CNT_W-1:0]       fill_inc;
    logic [dssh_pkg::CNT_W-1:0]       clamped;
    logic [dssh_pkg::SEEN_W-1:0]      need;
    logic [dssh_pkg::SEEN_W:0]        seen_inc;
    logic                             fire;

    // channels above 63 have no mask bit
    assign chan_ok  = (i_rx_byte[7:6] == 2'b00) &&
                      i_cfg.valid_channel_mask[i_rx_byte[5:0]];
    assign fill_inc = r_fill_index + dssh_pkg::CNT_W'(1);
    assign clamped  = (i_rx_byte > 8'(dssh_pkg::MAX_CHANNELS)) ?
                      dssh_pkg::CNT_W'(dssh_pkg::MAX_CHANNELS) :
                      dssh_pkg::CNT_W'(i_rx_byte);
    // zero repeats acts as one
    assign need     = (i_cfg.restart_repeats == '0) ?
                      dssh_pkg::SEEN_W'(1) : i_cfg.restart_repeats;
    assign seen_inc = {1'b0, r_seen} + (dssh_pkg::SEEN_W + 1)'(1);
    assign fire     = (seen_inc >= {1'b0, need});
    assign tbl_we   = i_accept && (r_phase == PH_FILL) && chan_ok &&
                      (r_fill_index < dssh_pkg::CNT_W'(dssh_pkg::MAX_CHANNELS));

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_fill_index = r_fill_index;
        n_seen       = r_seen;
        o_res        = '{valid: 1'b1, reply_byte: i_rx_byte,
                         restart_request: 1'b0, setup_done: 1'b0};
        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == i_cfg.confirm_byte) begin
                    n_phase          = PH_COUNT;
                    o_res.reply_byte = dssh_pkg::REPLY_ACK;
                end else begin
                    o_res.reply_byte = dssh_pkg::REPLY_SYNC_FAIL;
                end
            end
            PH_COUNT: begin
                n_count      = clamped;
                n_fill_index = '0;
                if (clamped == '0) begin
                    n_phase          = PH_RUN;
                    n_seen           = '0;
                    o_res.setup_done = 1'b1;
                end else begin
                    n_phase = PH_FILL;
                end
            end
            PH_FILL: begin
                if (!chan_ok) begin
                    o_res.reply_byte = dssh_pkg::REPLY_BAD_CHANNEL;
                end else begin
                    n_fill_index = fill_inc;
                    if (fill_inc >= r_count) begin
                        n_phase          = PH_RUN;
                        n_seen           = '0;
                        o_res.setup_done = 1'b1;
                    end
                end
            end
            PH_RUN: begin
                if (i_rx_byte != i_cfg.restart_byte) begin
                    n_seen      = '0;
                    o_res.valid = 1'b0;
                end else if (fire) begin
                    n_phase               = PH_IDLE;
                    n_count               = '0;
                    n_fill_index          = '0;
                    n_seen                = '0;
                    o_res.restart_request = 1'b1;
                end else begin
                    n_seen = seen_inc[dssh_pkg::SEEN_W-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_count      <= '0;
            r_fill_index <= '0;
            r_seen       <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_fill_index <= n_fill_index;
            r_seen       <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[r_fill_index[dssh_pkg::IDX_W-1:0]] <= i_rx_byte[dssh_pkg::CHAN_W-1:0];
        end
    end

endmodule

// ===== rtl/daq_serial_setup_handshake.sv =====
// Top level of the serial setup handshake block: stream ports, APB port,
// output register. Depends on dssh_pkg, dssh_regs and dssh_ctrl.
//
// One received byte is taken per clock cycle while o_s_axis_tready is high.
// Its reply, if any, is decoded in the same cycle and sits in the output
// register from the next cycle. o_s_axis_tready is low only while the output register
// holds an item that the sink is not taking; otherwise a new byte is taken
// every cycle, also while a finished reply is being handed over. In run mode
// a byte other than the restart byte gives no reply and cancels any restart
// run in progress. The channel table has no reset and no clearing pass; the
// block is ready out of reset. Register writes take effect at once and are
// meant for idle periods.
module daq_serial_setup_handshake (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] rx_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,   // [7:0] reply_byte
    output logic [1:0]                  o_m_axis_tuser,   // [0] restart_request, [1] setup_done
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dssh_pkg::ADDR_W-1:0] paddr,
    input  logic [dssh_pkg::DATA_W-1:0] pwdata,
    output logic [dssh_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    dssh_pkg::t_cfg    cfg;
    dssh_pkg::t_result res;
    logic              accept;

    logic              r_valid;
    logic [7:0]        r_reply;
    logic [1:0]        r_user;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    dssh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dssh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_s_axis_tdata),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= res.valid;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_reply <= res.reply_byte;
            r_user  <= {res.setup_done, res.restart_request};
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_reply;
    assign o_m_axis_tuser  = r_user;

endmodule

// ===== rtl/dssh_checker.sv =====
// Port-level checks for the serial setup handshake block, bound to the top.
// Has no dependencies; port widths are given as literals.
module dssh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [7:0]                  o_m_axis_tdata,
    input logic [1:0]                  o_m_axis_tuser,
    input logic                        pready
);

    // no item survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // input stalls only behind a blocked full output register
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");

    // one reply cannot both finish setup and request a restart
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("setup_done and restart_request together");

    // setup ends on a zero count or a valid channel, both below 64
    a_done_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata[7:6] == 2'b00))
        else $error("setup_done on a reply that is no channel echo");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind daq_serial_setup_handshake dssh_checker u_dssh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .pready          (pready)
);
